@@ rtl/core/rbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rbp_pkg
// shared types, codes and reset values for the receive byte packetizer
// ----------------------------------------------------------------------------
package rbp_pkg;

	localparam int BYTE_W   = 8;
	localparam int FLEN_W   = 5;
	localparam int TICKS_W  = 8;
	localparam int CAUSE_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DEPTH_DEF = 16;

	// register reset values
	localparam logic [FLEN_W-1:0]  FLUSH_LENGTH_RST   = FLEN_W'(10);
	localparam logic [BYTE_W-1:0]  DELIMITER_BYTE_RST = BYTE_W'(10);
	localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST  = TICKS_W'(8);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH_LENGTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_BYTE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = CFG_IDX_W'(2);

	// input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// flush causes
	localparam logic [CAUSE_W-1:0] CAUSE_FULL    = CAUSE_W'(0);
	localparam logic [CAUSE_W-1:0] CAUSE_DELIM   = CAUSE_W'(1);
	localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = CAUSE_W'(2);

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} state_t;

endpackage

@@ rtl/core/rbp_if.sv @@
// ----------------------------------------------------------------------------
// rbp_if
// valid/ready channels of the receive byte packetizer
// ----------------------------------------------------------------------------
interface rbp_in_if import rbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface rbp_out_if import rbp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  tx_byte;
	logic               last_of_run;
	logic [CAUSE_W-1:0] flush_cause;

	modport source (output valid, output tx_byte, output last_of_run, output flush_cause,
		input ready);
	modport sink   (input valid, input tx_byte, input last_of_run, input flush_cause,
		output ready);
endinterface

interface rbp_cfg_if import rbp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rbp_store.sv @@
// ----------------------------------------------------------------------------
// rbp_store
// byte store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module rbp_store import rbp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/rx_byte_packetizer_with_idle_timeout_core.sv @@
// ----------------------------------------------------------------------------
// rx_byte_packetizer_with_idle_timeout_core
// collects received bytes and flushes them as runs on full, delimiter or idle
// ----------------------------------------------------------------------------
// Each input item is either a received byte or one idle tick. Bytes are kept in
// a DEPTH-entry store and sent out oldest first as one run, the final byte
// flagged last_of_run, when the count reaches flush_length, when the delimiter
// byte arrives (it is part of the run) or when timeout_ticks ticks pass after
// the latest byte; full wins over delimiter. Ticks count only while armed, i.e.
// after a byte and before the next flush. A byte or tick that does not flush
// leaves the input open. One that flushes a run of n bytes keeps the input
// closed while the store's single read port streams one entry a cycle, when
// the output is not stalled, into the output register; the input opens again
// once the last read is issued, so the tail of a run may still sit in the
// output stage. A stalled output holds the drain. Configuration writes
// are taken every cycle and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module rx_byte_packetizer_with_idle_timeout_core import rbp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	rbp_in_if.sink  rx,
	rbp_out_if.source tx,
	rbp_cfg_if.sink cfg
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > FLEN_W) ? CW : FLEN_W;

	// configuration registers
	logic [FLEN_W-1:0]  flush_len_q;
	logic [BYTE_W-1:0]  delim_q;
	logic [TICKS_W-1:0] timeout_q;

	// collect side
	state_t             state_q, state_d;
	logic [CW-1:0]      fill_q;
	logic               armed_q;
	logic [TICKS_W-1:0] idle_q;

	// drain side
	logic [CW-1:0]      run_len_q;
	logic [CW-1:0]      rd_idx_q;
	logic [CAUSE_W-1:0] cause_q;
	logic               pend_s1;
	logic               last_s1;
	logic [CAUSE_W-1:0] cause_s1;

	// output register
	logic               ov_q;
	logic [BYTE_W-1:0]  tx_byte_q;
	logic               last_q;
	logic [CAUSE_W-1:0] tx_cause_q;

	logic               byte_acc, tick_acc;
	logic               room;
	logic [CW-1:0]      fill_nxt;
	logic [LW-1:0]      limit;
	logic               full_hit, delim_hit;
	logic [TICKS_W-1:0] idle_inc, to_limit;
	logic               to_hit;
	logic               flush_start;
	logic [CAUSE_W-1:0] flush_cause;
	logic [CW-1:0]      flush_len;
	logic               load, issue, issue_last;
	logic [BYTE_W-1:0]  rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_len_q <= FLUSH_LENGTH_RST;
			delim_q     <= DELIMITER_BYTE_RST;
			timeout_q   <= TIMEOUT_TICKS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FLUSH_LENGTH:   flush_len_q <= cfg.data[FLEN_W-1:0];
				REG_DELIMITER_BYTE: delim_q     <= cfg.data;
				REG_TIMEOUT_TICKS:  timeout_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// input is open only while collecting
	assign rx.ready = (state_q == ST_COLLECT);
	assign byte_acc = rx.valid && rx.ready && (rx.opcode == OP_BYTE);
	assign tick_acc = rx.valid && rx.ready && (rx.opcode == OP_TICK);

	// byte path: store, count, then full / delimiter check
	assign room     = (fill_q < CW'(DEPTH));
	assign fill_nxt = room ? (fill_q + CW'(1)) : fill_q;

	// flush length clamped into 1..DEPTH
	always_comb begin
		if (flush_len_q == '0) begin
			limit = LW'(1);
		end else if (LW'(flush_len_q) > LW'(DEPTH)) begin
			limit = LW'(DEPTH);
		end else begin
			limit = LW'(flush_len_q);
		end
	end

	assign full_hit  = (LW'(fill_nxt) >= limit);
	assign delim_hit = (rx.rx_byte == delim_q);

	// tick path: saturating idle count against timeout (zero acts as one)
	assign idle_inc = (idle_q == '1) ? idle_q : (idle_q + TICKS_W'(1));
	assign to_limit = (timeout_q == '0) ? TICKS_W'(1) : timeout_q;
	assign to_hit   = armed_q && (idle_inc == to_limit);

	always_comb begin
		flush_start = 1'b0;
		flush_cause = CAUSE_FULL;
		flush_len   = fill_q;
		if (byte_acc) begin
			flush_len = fill_nxt;
			if (full_hit) begin
				flush_start = 1'b1;
				flush_cause = CAUSE_FULL;
			end else if (delim_hit) begin
				flush_start = 1'b1;
				flush_cause = CAUSE_DELIM;
			end
		end else if (tick_acc && to_hit) begin
			flush_start = 1'b1;
			flush_cause = CAUSE_TIMEOUT;
		end
	end

	// drain: read issued when the read data stage is free or moving on
	assign load       = pend_s1 && (!ov_q || tx.ready);
	assign issue      = (state_q == ST_DRAIN) && (!pend_s1 || load);
	assign issue_last = (rd_idx_q == (run_len_q - CW'(1)));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (flush_start) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && issue_last) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// collect state and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			armed_q   <= 1'b0;
			idle_q    <= '0;
			run_len_q <= '0;
			rd_idx_q  <= '0;
			cause_q   <= CAUSE_FULL;
		end else begin
			if (flush_start) begin
				fill_q    <= '0;
				armed_q   <= 1'b0;
				idle_q    <= '0;
				run_len_q <= flush_len;
				rd_idx_q  <= '0;
				cause_q   <= flush_cause;
			end else begin
				if (byte_acc) begin
					fill_q  <= fill_nxt;
					armed_q <= 1'b1;
					idle_q  <= '0;
				end else if (tick_acc && armed_q) begin
					idle_q <= idle_inc;
				end
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
		end
	end

	rbp_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (byte_acc && room),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx.rx_byte),
		.re    (issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// read data stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (issue) begin
			pend_s1 <= 1'b1;
		end else if (load) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1  <= issue_last;
			cause_s1 <= cause_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (tx.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_byte_q  <= rdata;
			last_q     <= last_s1;
			tx_cause_q <= cause_s1;
		end
	end

	assign tx.valid       = ov_q;
	assign tx.tx_byte     = tx_byte_q;
	assign tx.last_of_run = last_q;
	assign tx.flush_cause = tx_cause_q;

endmodule
